// ----- hw/rtl/mbtlpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtlpm_pkg
// shared types, codes and helpers of the stride-4 trie lookup engine
// ----------------------------------------------------------------------------

package mbtlpm_pkg;

    // default sizing of the node stores
    localparam int DEF_NODE_CAPACITY = 4096;
    localparam int DEF_HOP_WIDTH     = 16;

    // trie geometry
    localparam int STRIDE_FANOUT = 16;
    localparam int NIB_W         = 4;
    localparam int LEVEL_W       = 4;
    localparam int ADDR_W        = 32;
    localparam int LEN_W         = 6;
    localparam int OUT_HOP_W     = 16;
    localparam int OUT_CNT_W     = 13;
    localparam logic [LEN_W-1:0] MAX_PREFIX = 6'd32;

    // item kind on the input side
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } seq_state_t;

    // control of the node stores for one cycle
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic hop_we;
        logic link_we;
    } mem_ctl_t;

    // one finished result word
    typedef struct packed {
        logic [OUT_CNT_W-1:0] nodes_in_use;
        logic                 status;
        logic [OUT_HOP_W-1:0] match_hop;
    } result_t;

    // nibble of the address at a trie level, most significant first
    function automatic logic [NIB_W-1:0] nibble_at(logic [ADDR_W-1:0] a, logic [2:0] lv);
        logic [4:0] base;
        base = {~lv, 2'b00};
        return a[base +: NIB_W];
    endfunction

    // number of levels walked for a prefix length, clamped at 32 bits
    function automatic logic [LEVEL_W-1:0] levels_for(logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] len_c;
        logic [LEN_W:0]   sum;
        len_c = (len > MAX_PREFIX) ? MAX_PREFIX : len;
        sum   = {1'b0, len_c} + 7'd3;
        return sum[LEN_W-1:2];
    endfunction

endpackage

// ----- hw/rtl/mbtlpm_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtlpm_mem
// node stores: one hop and one row of sixteen child links per trie node
// ----------------------------------------------------------------------------

module mbtlpm_mem
    import mbtlpm_pkg::*;
#(
    parameter int NODE_CAPACITY = DEF_NODE_CAPACITY,
    parameter int HOP_WIDTH     = DEF_HOP_WIDTH,
    localparam int NODE_W       = $clog2(NODE_CAPACITY)
)
(
    input  logic                                  clk,
    input  mem_ctl_t                              ctl,
    input  logic [NODE_W-1:0]                     rd_node,
    input  logic [NODE_W-1:0]                     wr_node,
    input  logic [NIB_W-1:0]                      wr_nib,
    input  logic [NODE_W-1:0]                     wr_link,
    input  logic [HOP_WIDTH-1:0]                  wr_hop,
    output logic [HOP_WIDTH-1:0]                  hop_q,
    output logic [STRIDE_FANOUT-1:0][NODE_W-1:0]  row_q
);

    logic [HOP_WIDTH-1:0]                 hop_mem  [NODE_CAPACITY];
    logic [STRIDE_FANOUT-1:0][NODE_W-1:0] link_mem [NODE_CAPACITY];

    // one write port, clear writes a whole zero row
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            hop_mem[wr_node]  <= '0;
            link_mem[wr_node] <= '0;
        end
        else
        begin
            if (ctl.hop_we)
            begin
                hop_mem[wr_node] <= wr_hop;
            end
            if (ctl.link_we)
            begin
                link_mem[wr_node][wr_nib] <= wr_link;
            end
        end
    end

    // registered read of one node
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            hop_q <= hop_mem[rd_node];
            row_q <= link_mem[rd_node];
        end
    end

endmodule

// ----- hw/rtl/mbtlpm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtlpm_seq
// walk sequencer: one trie level per cycle through the node store read port
// ----------------------------------------------------------------------------

module mbtlpm_seq
    import mbtlpm_pkg::*;
#(
    parameter int NODE_CAPACITY = DEF_NODE_CAPACITY,
    parameter int HOP_WIDTH     = DEF_HOP_WIDTH,
    localparam int NODE_W       = $clog2(NODE_CAPACITY),
    localparam int CNT_W        = $clog2(NODE_CAPACITY + 1)
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_mode,
    input  logic [ADDR_W-1:0]                     in_addr,
    input  logic [LEN_W-1:0]                      in_len,
    input  logic [OUT_HOP_W-1:0]                  in_hop,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output result_t                               res,
    output mem_ctl_t                              mem_ctl,
    output logic [NODE_W-1:0]                     rd_node,
    output logic [NODE_W-1:0]                     wr_node,
    output logic [NIB_W-1:0]                      wr_nib,
    output logic [NODE_W-1:0]                     wr_link,
    output logic [HOP_WIDTH-1:0]                  wr_hop,
    input  logic [HOP_WIDTH-1:0]                  hop_q,
    input  logic [STRIDE_FANOUT-1:0][NODE_W-1:0]  row_q
);

    seq_state_t             state_reg, state_next;
    logic [NODE_W-1:0]      clr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [NODE_W-1:0]      node_reg;
    logic [LEVEL_W-1:0]     lv_reg;
    logic [LEVEL_W-1:0]     levels_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   mode_reg;
    logic [HOP_WIDTH-1:0]   hopin_reg;
    logic [HOP_WIDTH-1:0]   acc_reg;
    logic                   status_reg;

    logic [NIB_W-1:0]       nib;
    logic [NODE_W-1:0]      link;
    logic                   link_zero;
    logic                   at_end;
    logic                   full;
    logic                   walk_done;
    logic [NODE_W-1:0]      next_node;
    logic                   accept;
    logic [31:0]            hop_ext;
    logic [31:0]            acc_ext;
    logic [31:0]            cnt_ext;

    // decisions of the current level
    always_comb
    begin
        nib       = nibble_at(addr_reg, lv_reg[2:0]);
        link      = row_q[nib];
        link_zero = (link == '0);
        at_end    = (lv_reg == levels_reg);
        full      = (count_reg >= CNT_W'(NODE_CAPACITY));
        next_node = link_zero ? count_reg[NODE_W-1:0] : link;
        if (mode_reg == MODE_LOOKUP)
        begin
            walk_done = at_end || link_zero;
        end
        else
        begin
            walk_done = at_end || (link_zero && full);
        end
    end

    assign accept = (state_reg == ST_IDLE) && in_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == NODE_W'(NODE_CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_ctl         = '0;
        rd_node         = next_node;
        wr_node         = node_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.clear = 1'b1;
                wr_node       = clr_reg;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                mem_ctl.rd_en = in_valid;
                rd_node       = '0;
            end
            ST_WALK:
            begin
                mem_ctl.rd_en   = !walk_done;
                mem_ctl.hop_we  = (mode_reg == MODE_INSERT) && at_end;
                mem_ctl.link_we = (mode_reg == MODE_INSERT) && !at_end && link_zero && !full;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_nib  = nib;
    assign wr_link = count_reg[NODE_W-1:0];
    assign wr_hop  = hopin_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (mem_ctl.link_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign hop_ext = 32'(in_hop);

    // walk datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= in_addr;
            mode_reg   <= in_mode;
            levels_reg <= levels_for(in_len);
            hopin_reg  <= hop_ext[HOP_WIDTH-1:0];
            node_reg   <= '0;
            lv_reg     <= '0;
            acc_reg    <= '0;
            status_reg <= STATUS_OK;
        end
        else if (state_reg == ST_WALK)
        begin
            if ((mode_reg == MODE_LOOKUP) && (hop_q != '0))
            begin
                acc_reg <= hop_q;
            end
            if (!walk_done)
            begin
                node_reg <= next_node;
                lv_reg   <= lv_reg + 1'b1;
            end
            if ((mode_reg == MODE_INSERT) && !at_end && link_zero && full)
            begin
                status_reg <= STATUS_FULL;
            end
        end
    end

    assign acc_ext = 32'(acc_reg);
    assign cnt_ext = 32'(count_reg);

    always_comb
    begin
        res.match_hop    = acc_ext[OUT_HOP_W-1:0];
        res.status       = status_reg;
        res.nodes_in_use = cnt_ext[OUT_CNT_W-1:0];
    end

endmodule

// ----- hw/rtl/multibit_trie_lpm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_lpm
// ipv4 longest-prefix-match engine on a stride-4 multibit trie
// ----------------------------------------------------------------------------
// Each input word either inserts a route prefix (tuser low) or looks up an
// address (tuser high) and gives exactly one result word. After reset the
// block first sweeps its node stores clean, one node row per cycle, with
// s_tready low during that pass. The walk then visits one trie level per
// cycle, because the next node address comes from the registered read of
// the current node row, so an item with k = ceil(len/4) levels (len clamped
// at 32) holds the block from acceptance until its result enters the output
// register and the block is ready again; a lookup that runs off the trie or
// an insert that finds the pool full ends its walk early, and a finished
// result that cannot yet enter the output register holds the block in its
// done state until it can.
// The result lands in an output register, so the block takes the next word
// while that result still waits for m_tready. Prefixes are rounded up to
// whole nibbles without expansion; when an insert needs a node and the pool
// is full it stops there, keeps the nodes it already linked and reports full.
// ----------------------------------------------------------------------------

module multibit_trie_lpm
    import mbtlpm_pkg::*;
#(
    parameter int NODE_CAPACITY = DEF_NODE_CAPACITY,
    parameter int HOP_WIDTH     = DEF_HOP_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address[31:0], prefix_len[37:32], route_hop[53:38], zero
    input  logic        s_tuser,   // mode: 0 insert, 1 lookup
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // match_hop[15:0], status[16], nodes_in_use[29:17], zero
);

    localparam int NODE_W = $clog2(NODE_CAPACITY);

    mem_ctl_t                              mem_ctl;
    logic [NODE_W-1:0]                     rd_node;
    logic [NODE_W-1:0]                     wr_node;
    logic [NIB_W-1:0]                      wr_nib;
    logic [NODE_W-1:0]                     wr_link;
    logic [HOP_WIDTH-1:0]                  wr_hop;
    logic [HOP_WIDTH-1:0]                  hop_q;
    logic [STRIDE_FANOUT-1:0][NODE_W-1:0]  row_q;

    logic       res_valid;
    logic       res_ready;
    result_t    res;

    logic       m_tvalid_reg;
    result_t    out_reg;

    // walk sequencer
    mbtlpm_seq #(
        .NODE_CAPACITY (NODE_CAPACITY),
        .HOP_WIDTH     (HOP_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_addr   (s_tdata[31:0]),
        .in_len    (s_tdata[37:32]),
        .in_hop    (s_tdata[53:38]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .rd_node   (rd_node),
        .wr_node   (wr_node),
        .wr_nib    (wr_nib),
        .wr_link   (wr_link),
        .wr_hop    (wr_hop),
        .hop_q     (hop_q),
        .row_q     (row_q)
    );

    // node hop and child link stores
    mbtlpm_mem #(
        .NODE_CAPACITY (NODE_CAPACITY),
        .HOP_WIDTH     (HOP_WIDTH)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_node (rd_node),
        .wr_node (wr_node),
        .wr_nib  (wr_nib),
        .wr_link (wr_link),
        .wr_hop  (wr_hop),
        .hop_q   (hop_q),
        .row_q   (row_q)
    );

    // output register frees the sequencer while a result waits
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.nodes_in_use, out_reg.status, out_reg.match_hop};

endmodule

// ----- verif/multibit_trie_lpm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_lpm_tb
// self-checking bench for the stride-4 trie longest-prefix-match engine
// ----------------------------------------------------------------------------
// Sends insert and lookup words, keeps a shadow copy of the trie to work out
// the result word of each accepted word, and compares every result field by
// field in arrival order. Covers directed corner cases, a back-to-back run,
// random route sets with lookups aimed at stored prefixes, and a fill of the
// node pool up to and past its capacity.
// ----------------------------------------------------------------------------

module multibit_trie_lpm_tb;
    import mbtlpm_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RST_CYCLES    = 7;
    localparam int NODE_CAP      = DEF_NODE_CAPACITY;
    localparam int IDLE_PCT      = 13;
    localparam int STALL_LIMIT   = 20000;   // covers the clearing pass after reset
    localparam int SETTLE_CYCLES = 20;
    localparam int BOOK_SIZE     = 256;

    typedef struct {
        logic [15:0] hop;
        logic        status;
        logic [12:0] nodes;
    } lpm_answer_t;

    typedef struct {
        logic [31:0] addr;
        logic [5:0]  len;
    } route_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;     // address[31:0], prefix_len[37:32], route_hop[53:38], zero
    logic        s_tuser  = 1'b0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // match_hop[15:0], status[16], nodes_in_use[29:17], zero

    // shadow trie
    logic [15:0] hop_mem  [NODE_CAP];
    logic [11:0] link_mem [NODE_CAP*STRIDE_FANOUT];
    int          node_total;

    lpm_answer_t answers[$];
    lpm_answer_t want_ans;
    route_t      route_book[$];

    bit gaps_off     = 1'b0;
    int err_cnt      = 0;
    int stall_cycles = 0;
    int n_insert     = 0;
    int n_full       = 0;
    int n_lookup     = 0;
    int n_hit        = 0;

    multibit_trie_lpm uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // walk the shadow trie for one word and return its result word
    function automatic lpm_answer_t trie_walk(input logic mode, input logic [31:0] addr,
                                              input logic [5:0] len, input logic [15:0] hop_in);
        lpm_answer_t r;
        int          levels;
        int          lv;
        int          k;
        int          node;
        int          nxt;
        int          li;
        bit          stopped;
        levels  = (len > 6'd32) ? 8 : (int'(len) + 3) / 4;
        node    = 0;
        stopped = 1'b0;
        r.hop    = '0;
        r.status = STATUS_OK;
        if (mode == MODE_INSERT)
        begin
            for (lv = 0; lv < levels && !stopped; lv++)
            begin
                li  = node * STRIDE_FANOUT + int'(addr[(28 - 4*lv) +: 4]);
                nxt = int'(link_mem[li]);
                if (nxt == 0)
                begin
                    if (node_total >= NODE_CAP)
                        stopped = 1'b1;
                    else
                    begin
                        nxt = node_total;
                        node_total++;
                        hop_mem[nxt] = '0;
                        for (k = 0; k < STRIDE_FANOUT; k++)
                            link_mem[nxt*STRIDE_FANOUT + k] = '0;
                        link_mem[li] = nxt[11:0];
                    end
                end
                node = nxt;
            end
            // pool ran out: links made so far stay, hop is not written
            if (stopped)
                r.status = STATUS_FULL;
            else
                hop_mem[node] = hop_in;
        end
        else
        begin
            for (lv = 0; lv < levels && !stopped; lv++)
            begin
                if (hop_mem[node] != '0)
                    r.hop = hop_mem[node];
                node = int'(link_mem[node * STRIDE_FANOUT + int'(addr[(28 - 4*lv) +: 4])]);
                if (node == 0)
                    stopped = 1'b1;
            end
            if (!stopped && hop_mem[node] != '0)
                r.hop = hop_mem[node];
        end
        r.nodes = node_total[12:0];
        return r;
    endfunction

    // keep the prefix bits of a route, randomize the rest
    function automatic logic [31:0] near_addr(input route_t rt);
        logic [31:0] keep;
        keep = (rt.len >= 6'd32) ? '1 : ~(32'hFFFF_FFFF >> rt.len);
        return (rt.addr & keep) | ($urandom & ~keep);
    endfunction

    // mostly nonzero, now and then zero to clear a stored hop
    function automatic logic [15:0] rand_hop();
        return ($urandom_range(19) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    // send one word and record the result it should give
    task automatic send_word(input logic mode, input logic [31:0] addr,
                             input logic [5:0] len, input logic [15:0] hop);
        lpm_answer_t r;
        route_t      rt;
        while (!gaps_off && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, hop, len, addr};
        do
            @(posedge clk);
        while (!s_tready);
        r = trie_walk(mode, addr, len, hop);
        answers.push_back(r);
        if (mode == MODE_INSERT)
        begin
            n_insert++;
            if (r.status == STATUS_FULL)
                n_full++;
            else
            begin
                rt.addr = addr;
                rt.len  = len;
                if (route_book.size() < BOOK_SIZE)
                    route_book.push_back(rt);
                else
                    route_book[$urandom_range(BOOK_SIZE - 1)] = rt;
            end
        end
        else
        begin
            n_lookup++;
            if (r.hop != '0)
                n_hit++;
        end
    endtask

    // lower tvalid, then wait for every outstanding result and the pipe to settle
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random words, mostly inserts and lookups built around stored routes
    task automatic route_traffic(input int count);
        int          i;
        int          pick;
        route_t      base;
        logic [5:0]  len;
        logic [31:0] addr;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (route_book.size() != 0)
                base = route_book[$urandom_range(route_book.size() - 1)];
            if (route_book.size() == 0 || pick < 10)
            begin
                // noise, any field value
                send_word(1'($urandom), $urandom, 6'($urandom_range(63)), 16'($urandom));
            end
            else if (pick < 22)
            begin
                // fresh branch
                send_word(MODE_INSERT, $urandom, 6'($urandom_range(32)), rand_hop());
            end
            else if (pick < 45)
            begin
                // nested route under an existing one, or the same one again
                len = (base.len > 6'd32) ? 6'd32 : base.len;
                len = 6'(int'(len) + $urandom_range(12));
                if (len > 6'd32)
                    len = 6'd32;
                send_word(MODE_INSERT, near_addr(base), len, rand_hop());
            end
            else
            begin
                addr = near_addr(base);
                len  = ($urandom_range(99) < 70) ? 6'd32 : 6'($urandom_range(40));
                send_word(MODE_LOOKUP, addr, len, 16'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        // empty trie
        send_word(MODE_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000);
        send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
        // root route with zero length
        send_word(MODE_INSERT, 32'h0000_0000, 6'd0,  16'hFFFF);
        send_word(MODE_LOOKUP, 32'h1234_5678, 6'd0,  16'h0000);
        send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'h0000);
        // nested prefixes, deepest wins
        send_word(MODE_INSERT, 32'h0A00_0000, 6'd8,  16'h0001);
        send_word(MODE_INSERT, 32'h0A01_0000, 6'd16, 16'h0002);
        send_word(MODE_LOOKUP, 32'h0A01_0203, 6'd32, 16'h0000);
        send_word(MODE_LOOKUP, 32'h0A02_0304, 6'd32, 16'h0000);
        // walk cut short by the lookup length
        send_word(MODE_LOOKUP, 32'h0A01_0203, 6'd8,  16'h0000);
        // length rounded up to a whole nibble lands on the /8 node
        send_word(MODE_INSERT, 32'h0A00_0000, 6'd5,  16'h0003);
        send_word(MODE_LOOKUP, 32'h0A7F_0000, 6'd12, 16'h0000);
        // full depth and lengths above 32
        send_word(MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hAAAA);
        send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h0000);
        send_word(MODE_LOOKUP, 32'hFFFF_FFFE, 6'd32, 16'h0000);
        send_word(MODE_INSERT, 32'hFFFF_FFFF, 6'd33, 16'h5555);
        send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'h0000);
        // zero hop clears a stored route
        send_word(MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0000);
        send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h0000);
        send_word(MODE_INSERT, 32'h0A01_0000, 6'd16, 16'h0000);
        send_word(MODE_LOOKUP, 32'h0A01_0203, 6'd32, 16'h0000);
        send_word(MODE_INSERT, 32'h8000_0001, 6'd31, 16'h8000);
        send_word(MODE_LOOKUP, 32'h8000_000F, 6'd28, 16'h0000);
        send_word(MODE_INSERT, 32'h0000_0000, 6'd0,  16'h0000);
        send_word(MODE_LOOKUP, 32'h0A01_0203, 6'd32, 16'h0000);
    endtask

    task automatic test_back_to_back(input int count);
        gaps_off = 1'b1;
        route_traffic(count);
        gaps_off = 1'b0;
    endtask

    task automatic test_random_routes(input int count);
        route_traffic(count);
    endtask

    // fill the pool with deep fresh routes, then keep going on a full store
    task automatic test_store_full();
        int guard;
        guard = 0;
        while (node_total < NODE_CAP && guard < 3000)
        begin
            send_word(MODE_INSERT, $urandom, 6'd32, 16'($urandom_range(1, 65535)));
            guard++;
        end
        route_traffic(150);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        m_tready <= gaps_off || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each result word with the oldest outstanding one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answers.size() == 0)
            begin
                $display("%0t ns: result word with none outstanding, expected none, got 0x%0h",
                         $time, m_tdata);
                err_cnt++;
            end
            else
            begin
                want_ans = answers.pop_front();
                check_field("match_hop", want_ans.hop, m_tdata[15:0]);
                check_field("status", 16'(want_ans.status), 16'(m_tdata[16]));
                check_field("nodes_in_use", 16'(want_ans.nodes), 16'(m_tdata[29:17]));
            end
        end
    end

    // cycles in which neither side moves a word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no word moved for %0d cycles", $time, stall_cycles);
            $display("multibit_trie_lpm_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NODE_CAP; i++)
            hop_mem[i] = '0;
        for (int i = 0; i < NODE_CAP*STRIDE_FANOUT; i++)
            link_mem[i] = '0;
        node_total = 1;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_results_drained();
        test_back_to_back(250);
        test_random_routes(850);
        // sender holds off until every result is back
        wait_results_drained();
        test_store_full();
        wait_results_drained();

        $display("covered %0d inserts (%0d refused on a full store), %0d lookups (%0d hits)",
                 n_insert, n_full, n_lookup, n_hit);
        $display("node pool ended at %0d of %0d nodes", node_total, NODE_CAP);
        if (err_cnt == 0 && answers.size() == 0)
            $display("multibit_trie_lpm_tb: PASS");
        else
            $display("multibit_trie_lpm_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mbtlpm_pkg.sv
hw/rtl/mbtlpm_mem.sv
hw/rtl/mbtlpm_seq.sv
hw/rtl/multibit_trie_lpm.sv
verif/multibit_trie_lpm_tb.sv
